>>> hw/rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FPT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define FPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/fpt_pkg.sv
// shared types, memory map and decode functions of the frame point transform
package fpt_pkg;

  // memory map of the datapath word store
  localparam int MEM_DEPTH = 58;
  localparam int VLD_DEPTH = 30;
  localparam logic [4:0] CALIB_DEPTH = 5'd21;
  localparam logic [5:0] RCG_BASE = 6'd0;
  localparam logic [5:0] RGI_BASE = 6'd9;
  localparam logic [5:0] T_BASE   = 6'd18;
  localparam logic [5:0] GW_BASE  = 6'd21;
  localparam logic [5:0] P_BASE   = 6'd30;
  localparam logic [5:0] QX_ADDR  = 6'd30;
  localparam logic [5:0] QY_ADDR  = 6'd31;
  localparam logic [5:0] QZ_ADDR  = 6'd32;
  localparam logic [5:0] QW_ADDR  = 6'd33;
  localparam logic [5:0] RQ_BASE  = 6'd34;
  localparam logic [5:0] TMP_BASE = 6'd43;
  localparam logic [5:0] VA_BASE  = 6'd52;
  localparam logic [5:0] VB_BASE  = 6'd55;

  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_IMU   = 2'd1,
    CMD_XFORM = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    FR_CAM   = 2'd0,
    FR_GIM   = 2'd1,
    FR_WORLD = 2'd2,
    FR_IMU   = 2'd3
  } frame_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAP,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } ctrl_state_t;

  typedef enum logic [3:0] {
    PH_RQ,
    PH_TMP,
    PH_GW,
    PH_FWD0,
    PH_FWD1,
    PH_BACK,
    PH_SUB,
    PH_CAM,
    PH_COPY,
    PH_END
  } phase_t;

  // scale applied to one rounded product
  typedef enum logic [1:0] {
    CF_P1,
    CF_M1,
    CF_P2,
    CF_M2
  } coef_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] a_addr;
    logic [5:0] b_addr;
    logic       a_one;
    logic       b_one;
    coef_t      coef;
    logic       first;
    logic       last;
    logic       to_out;
    logic [5:0] dest;
    logic [1:0] out_idx;
  } mac_op_t;

  typedef struct packed {
    logic       load_en;
    logic       cap_en;
    logic       cap_wr;
    logic [1:0] cap_idx;
    logic       out_load;
    mac_op_t    op;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] a_addr;
    logic [5:0] b_addr;
    logic       a_one;
    logic       b_one;
    coef_t      coef;
  } rq_term_t;

  // v * 3 for matrix row offsets
  function automatic logic [5:0] mul3(input logic [1:0] v);
    mul3 = {3'b000, v, 1'b0} + {4'b0000, v};
  endfunction

  // terms of the quaternion to matrix formula, entry e, term k
  function automatic rq_term_t rq_term(input logic [5:0] e, input logic [1:0] k);
    rq_term_t t;
    t = '{a_addr: QX_ADDR, b_addr: QX_ADDR, a_one: 1'b0, b_one: 1'b0, coef: CF_P1};
    case (e)
      6'd0, 6'd4, 6'd8: begin
        case (k)
          2'd0: begin
            t.a_one = 1'b1;
            t.b_one = 1'b1;
          end
          2'd1: begin
            t.a_addr = (e == 6'd0) ? QY_ADDR : QX_ADDR;
            t.b_addr = t.a_addr;
            t.coef   = CF_M2;
          end
          default: begin
            t.a_addr = (e == 6'd8) ? QY_ADDR : QZ_ADDR;
            t.b_addr = t.a_addr;
            t.coef   = CF_M2;
          end
        endcase
      end
      6'd1, 6'd3: begin
        t.a_addr = (k == 2'd0) ? QX_ADDR : QZ_ADDR;
        t.b_addr = (k == 2'd0) ? QY_ADDR : QW_ADDR;
        t.coef   = (k == 2'd0 || e == 6'd3) ? CF_P2 : CF_M2;
      end
      6'd2, 6'd6: begin
        t.a_addr = (k == 2'd0) ? QX_ADDR : QY_ADDR;
        t.b_addr = (k == 2'd0) ? QZ_ADDR : QW_ADDR;
        t.coef   = (k == 2'd0 || e == 6'd2) ? CF_P2 : CF_M2;
      end
      6'd5, 6'd7: begin
        t.a_addr = (k == 2'd0) ? QY_ADDR : QX_ADDR;
        t.b_addr = (k == 2'd0) ? QZ_ADDR : QW_ADDR;
        t.coef   = (k == 2'd0 || e == 6'd7) ? CF_P2 : CF_M2;
      end
      default: begin
        t.coef = CF_P1;
      end
    endcase
    rq_term = t;
  endfunction

endpackage

>>> hw/rtl/fpt_dp.sv
// datapath: word store, shared multiply-accumulate, result and output registers
module fpt_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  fpt_pkg::dp_cmd_t    cmd,
  input  logic [4:0]          in_calib_index,
  input  logic signed [31:0]  in_calib_word,
  input  logic signed [31:0]  in_px,
  input  logic signed [31:0]  in_py,
  input  logic signed [31:0]  in_pz,
  input  logic signed [31:0]  in_qw,
  output logic                dp_busy,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z
);
  import fpt_pkg::*;

  logic signed [31:0] mem [MEM_DEPTH];
  logic [VLD_DEPTH-1:0] vld_r;
  logic signed [31:0] cap_r [4];
  logic signed [31:0] res_r [3];
  mac_op_t            op_s1_r;
  mac_op_t            op_s2_r;
  logic signed [31:0] rd_a_r;
  logic signed [31:0] rd_b_r;
  logic signed [63:0] prod_r;
  logic signed [39:0] acc_r;
  logic signed [39:0] acc_nxt;
  logic signed [63:0] rnd;
  logic signed [33:0] term;
  logic signed [35:0] scaled;
  logic signed [31:0] sat;
  logic signed [31:0] out_x_r;
  logic signed [31:0] out_y_r;
  logic signed [31:0] out_z_r;
  logic               we;
  logic [5:0]         waddr;
  logic signed [31:0] wdata;
  logic               wb_fire;

  // reset contents: identity rotations, zero translation
  function automatic logic signed [31:0] rst_word(input logic [5:0] a);
    case (a)
      6'd0, 6'd4, 6'd8, 6'd9, 6'd13, 6'd17, 6'd21, 6'd25, 6'd29: rst_word = ONE_Q30;
      default: rst_word = 32'sd0;
    endcase
  endfunction

  function automatic logic signed [31:0] rd_word(input logic [5:0] a,
                                                 input logic [VLD_DEPTH-1:0] v,
                                                 input logic signed [31:0] m);
    if (a < 6'(VLD_DEPTH) && !v[a[4:0]]) rd_word = rst_word(a);
    else rd_word = m;
  endfunction

  // rounded product, scale, accumulate and saturate
  always_comb begin
    rnd  = prod_r + 64'sd536870912;
    term = rnd[63:30];
    case (op_s2_r.coef)
      CF_P1:   scaled = 36'(term);
      CF_M1:   scaled = -36'(term);
      CF_P2:   scaled = 36'(term) <<< 1;
      default: scaled = -(36'(term) <<< 1);
    endcase
    acc_nxt = (op_s2_r.first ? 40'sd0 : acc_r) + 40'(scaled);
    if (acc_nxt > 40'sd2147483647) sat = 32'sh7fff_ffff;
    else if (acc_nxt < -40'sd2147483648) sat = 32'sh8000_0000;
    else sat = acc_nxt[31:0];
  end

  assign wb_fire = op_s2_r.valid && op_s2_r.last;

  // single write port of the store
  always_comb begin
    we    = 1'b0;
    waddr = op_s2_r.dest;
    wdata = sat;
    if (cmd.load_en && in_calib_index < CALIB_DEPTH) begin
      we    = 1'b1;
      waddr = {1'b0, in_calib_index};
      wdata = in_calib_word;
    end else if (cmd.cap_wr) begin
      we    = 1'b1;
      waddr = P_BASE + {4'b0000, cmd.cap_idx};
      wdata = cap_r[cmd.cap_idx];
    end else if (wb_fire && !op_s2_r.to_out) begin
      we = 1'b1;
    end
  end

  // store with registered operand reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_r <= cmd.op.a_one ? ONE_Q30 : rd_word(cmd.op.a_addr, vld_r, mem[cmd.op.a_addr]);
    rd_b_r <= cmd.op.b_one ? ONE_Q30 : rd_word(cmd.op.b_addr, vld_r, mem[cmd.op.b_addr]);
  end

  // written marks for the entries with a reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we && waddr < 6'(VLD_DEPTH)) begin
      vld_r[waddr[4:0]] <= 1'b1;
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_s1_r <= '0;
      op_s2_r <= '0;
    end else begin
      op_s1_r <= cmd.op;
      op_s2_r <= op_s1_r;
    end
  end

  // multiply, accumulate and result capture
  always_ff @(posedge clk) begin
    prod_r <= rd_a_r * rd_b_r;
    if (op_s2_r.valid) begin
      acc_r <= acc_nxt;
    end
    if (wb_fire && op_s2_r.to_out) begin
      res_r[op_s2_r.out_idx] <= sat;
    end
    if (cmd.cap_en) begin
      cap_r[0] <= in_px;
      cap_r[1] <= in_py;
      cap_r[2] <= in_pz;
      cap_r[3] <= in_qw;
    end
    if (cmd.out_load) begin
      out_x_r <= res_r[0];
      out_y_r <= res_r[1];
      out_z_r <= res_r[2];
    end
  end

  assign dp_busy = op_s1_r.valid | op_s2_r.valid;
  assign out_x   = out_x_r;
  assign out_y   = out_y_r;
  assign out_z   = out_z_r;

endmodule

>>> hw/rtl/fpt_ctrl.sv
// controller: command sequencing and multiply-accumulate op issue
module fpt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_cmd,
  input  logic [1:0]       in_from_frame,
  input  logic [1:0]       in_to_frame,
  output logic             out_valid,
  input  logic             out_stall,
  input  logic             dp_busy,
  output fpt_pkg::dp_cmd_t dp_cmd
);
  import fpt_pkg::*;

  ctrl_state_t state_r, state_nxt;
  phase_t      phase_r, phase_nxt;
  cmd_t        cmd_r, cmd_nxt;
  frame_t      from_r, from_nxt;
  frame_t      to_r, to_nxt;
  logic [1:0]  ri_r, ri_nxt;
  logic [1:0]  rj_r, rj_nxt;
  logic [1:0]  k_r, k_nxt;
  logic [1:0]  cap_r, cap_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        accept;
  logic        mat9;
  logic [1:0]  k_last;
  logic        last_term;
  logic        last_col;
  logic        last_row;
  logic        hand_off;
  phase_t      drain_ph;
  logic [5:0]  i6, k6, i3, k3, e6;
  logic [5:0]  world_base;
  logic [5:0]  copy_base;
  rq_term_t    rq;

  function automatic phase_t to_phase(input frame_t t);
    to_phase = (t == FR_CAM || t == FR_GIM) ? PH_BACK : PH_COPY;
  endfunction

  function automatic phase_t first_phase(input frame_t f, input frame_t t);
    if (f == t) first_phase = PH_COPY;
    else if (f == FR_CAM) first_phase = PH_FWD0;
    else if (f == FR_GIM) first_phase = PH_FWD1;
    else first_phase = to_phase(t);
  endfunction

  function automatic phase_t next_phase(input phase_t p, input frame_t t);
    case (p)
      PH_RQ:   next_phase = PH_TMP;
      PH_TMP:  next_phase = PH_GW;
      PH_FWD0: next_phase = PH_FWD1;
      PH_FWD1: next_phase = to_phase(t);
      PH_BACK: next_phase = (t == FR_CAM) ? PH_SUB : PH_END;
      PH_SUB:  next_phase = PH_CAM;
      default: next_phase = PH_END;
    endcase
  endfunction

  // loop bounds of the current phase
  always_comb begin
    mat9 = (phase_r == PH_RQ) || (phase_r == PH_TMP) || (phase_r == PH_GW);
    case (phase_r)
      PH_RQ:   k_last = (ri_r == rj_r) ? 2'd2 : 2'd1;
      PH_FWD0: k_last = 2'd3;
      PH_SUB:  k_last = 2'd1;
      PH_COPY: k_last = 2'd0;
      default: k_last = 2'd2;
    endcase
  end

  assign accept    = in_valid && (state_r == ST_IDLE);
  assign last_term = (k_r == k_last);
  assign last_col  = !mat9 || (rj_r == 2'd2);
  assign last_row  = (ri_r == 2'd2);
  assign hand_off  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign drain_ph  = next_phase(phase_r, to_r);

  // next state and loop counters
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    from_nxt  = from_r;
    to_nxt    = to_r;
    ri_nxt    = ri_r;
    rj_nxt    = rj_r;
    k_nxt     = k_r;
    cap_nxt   = cap_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt  = cmd_t'(in_cmd);
          from_nxt = frame_t'(in_from_frame);
          to_nxt   = frame_t'(in_to_frame);
          cap_nxt  = 2'd0;
          if (in_cmd == CMD_IMU || in_cmd == CMD_XFORM) begin
            state_nxt = ST_CAP;
          end
        end
      end
      ST_CAP: begin
        cap_nxt = cap_r + 2'd1;
        if (cap_r == 2'd3) begin
          state_nxt = ST_RUN;
          phase_nxt = (cmd_r == CMD_IMU) ? PH_RQ : first_phase(from_r, to_r);
          ri_nxt    = 2'd0;
          rj_nxt    = 2'd0;
          k_nxt     = 2'd0;
        end
      end
      ST_RUN: begin
        if (last_term) begin
          k_nxt = 2'd0;
          if (last_col) begin
            rj_nxt = 2'd0;
            if (last_row) begin
              ri_nxt    = 2'd0;
              state_nxt = ST_DRAIN;
            end else begin
              ri_nxt = ri_r + 2'd1;
            end
          end else begin
            rj_nxt = rj_r + 2'd1;
          end
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      ST_DRAIN: begin
        if (!dp_busy) begin
          if (drain_ph == PH_END) begin
            state_nxt = (cmd_r == CMD_XFORM) ? ST_DONE : ST_IDLE;
          end else begin
            state_nxt = ST_RUN;
            phase_nxt = drain_ph;
          end
        end
      end
      ST_DONE: begin
        if (hand_off) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // operand index helpers
  always_comb begin
    i6 = {4'b0000, ri_r};
    k6 = {4'b0000, k_r};
    i3 = mul3(ri_r);
    k3 = mul3(k_r);
    e6 = i3 + {4'b0000, rj_r};
    world_base = (from_r == FR_CAM || from_r == FR_GIM) ? VB_BASE : P_BASE;
    copy_base  = (from_r == to_r) ? P_BASE : world_base;
    rq = rq_term(e6, k_r);
  end

  // outputs and op issue
  always_comb begin
    dp_cmd          = '0;
    dp_cmd.load_en  = accept && (in_cmd == CMD_LOAD);
    dp_cmd.cap_en   = accept && (in_cmd == CMD_IMU || in_cmd == CMD_XFORM);
    dp_cmd.cap_wr   = (state_r == ST_CAP);
    dp_cmd.cap_idx  = cap_r;
    dp_cmd.out_load = hand_off;
    in_stall        = (state_r != ST_IDLE);
    out_valid_nxt   = hand_off ? 1'b1 : (out_valid_r && !out_stall ? 1'b0 : out_valid_r);
    if (state_r == ST_RUN) begin
      dp_cmd.op.valid   = 1'b1;
      dp_cmd.op.first   = (k_r == 2'd0);
      dp_cmd.op.last    = last_term;
      dp_cmd.op.coef    = CF_P1;
      dp_cmd.op.out_idx = ri_r;
      unique case (phase_r)
        PH_RQ: begin
          dp_cmd.op.a_addr = rq.a_addr;
          dp_cmd.op.b_addr = rq.b_addr;
          dp_cmd.op.a_one  = rq.a_one;
          dp_cmd.op.b_one  = rq.b_one;
          dp_cmd.op.coef   = rq.coef;
          dp_cmd.op.dest   = RQ_BASE + e6;
        end
        PH_TMP: begin
          dp_cmd.op.a_addr = RQ_BASE + i3 + k6;
          dp_cmd.op.b_addr = RGI_BASE + k3 + {4'b0000, rj_r};
          dp_cmd.op.dest   = TMP_BASE + e6;
        end
        PH_GW: begin
          dp_cmd.op.a_addr = RGI_BASE + k3 + i6;
          dp_cmd.op.b_addr = TMP_BASE + k3 + {4'b0000, rj_r};
          dp_cmd.op.dest   = GW_BASE + e6;
        end
        PH_FWD0: begin
          // rotation row plus the translation term
          if (k_r == 2'd3) begin
            dp_cmd.op.a_addr = T_BASE + i6;
            dp_cmd.op.b_one  = 1'b1;
          end else begin
            dp_cmd.op.a_addr = RCG_BASE + i3 + k6;
            dp_cmd.op.b_addr = P_BASE + k6;
          end
          dp_cmd.op.dest = VA_BASE + i6;
        end
        PH_FWD1: begin
          dp_cmd.op.a_addr = GW_BASE + i3 + k6;
          dp_cmd.op.b_addr = ((from_r == FR_CAM) ? VA_BASE : P_BASE) + k6;
          dp_cmd.op.dest   = VB_BASE + i6;
        end
        PH_BACK: begin
          dp_cmd.op.a_addr = GW_BASE + k3 + i6;
          dp_cmd.op.b_addr = world_base + k6;
          dp_cmd.op.dest   = VA_BASE + i6;
          dp_cmd.op.to_out = (to_r == FR_GIM);
        end
        PH_SUB: begin
          // gimbal point minus translation
          dp_cmd.op.a_addr = (k_r == 2'd0) ? (VA_BASE + i6) : (T_BASE + i6);
          dp_cmd.op.b_one  = 1'b1;
          dp_cmd.op.coef   = (k_r == 2'd0) ? CF_P1 : CF_M1;
          dp_cmd.op.dest   = VB_BASE + i6;
        end
        PH_CAM: begin
          dp_cmd.op.a_addr = RCG_BASE + k3 + i6;
          dp_cmd.op.b_addr = VB_BASE + k6;
          dp_cmd.op.to_out = 1'b1;
        end
        PH_COPY: begin
          dp_cmd.op.a_addr = copy_base + i6;
          dp_cmd.op.b_one  = 1'b1;
          dp_cmd.op.to_out = 1'b1;
        end
        PH_END: begin
          dp_cmd.op.valid = 1'b0;
        end
        default: begin
          dp_cmd.op.valid = 1'b0;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_END;
      cmd_r       <= CMD_NONE;
      from_r      <= FR_CAM;
      to_r        <= FR_CAM;
      ri_r        <= 2'd0;
      rj_r        <= 2'd0;
      k_r         <= 2'd0;
      cap_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cmd_r       <= cmd_nxt;
      from_r      <= from_nxt;
      to_r        <= to_nxt;
      ri_r        <= ri_nxt;
      rj_r        <= rj_nxt;
      k_r         <= k_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/frame_point_transform_top.sv
// Frame point transform: one item at a time through one shared multiply-accumulate.
// Load item: written to the word store as it is accepted. IMU update: capture, 75 products and three drains.
// Transform: one product per cycle plus a drain per stage.
// The result waits in an output register while the next item is taken in.
// Reset (synchronous, rst_n low): identity rotations, zero translation, no result pending.
`include "assert_macros.svh"
module frame_point_transform_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic [4:0]         in_calib_index,
  input  logic signed [31:0] in_calib_word,
  input  logic signed [31:0] in_px,
  input  logic signed [31:0] in_py,
  input  logic signed [31:0] in_pz,
  input  logic signed [31:0] in_qw,
  input  logic [1:0]         in_from_frame,
  input  logic [1:0]         in_to_frame,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z
);
  import fpt_pkg::*;

  dp_cmd_t dp_cmd;
  logic    dp_busy;

  // sequencer
  fpt_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_from_frame (in_from_frame),
    .in_to_frame   (in_to_frame),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .dp_busy       (dp_busy),
    .dp_cmd        (dp_cmd)
  );

  // arithmetic and storage
  fpt_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (dp_cmd),
    .in_calib_index (in_calib_index),
    .in_calib_word  (in_calib_word),
    .in_px          (in_px),
    .in_py          (in_py),
    .in_pz          (in_pz),
    .in_qw          (in_qw),
    .dp_busy        (dp_busy),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_z          (out_z)
  );

  // checks
  `FPT_ASSERT_IMPL(a_idle_drained, !in_stall, !dp_busy, "item taken while pipeline busy")
  `FPT_ASSERT_IMPL(a_load_quiet, dp_cmd.load_en, !dp_busy && !dp_cmd.op.valid, "load during mac")
  `FPT_ASSERT_IMPL(a_no_overwrite, dp_cmd.out_load, !out_valid || !out_stall, "result overwritten")
  `FPT_ASSERT_NEXT(a_load_sets_valid, dp_cmd.out_load, out_valid, "result not presented")

endmodule

>>> bench/fpt_checker.sv
// checker for the frame point transform: predicts every result and compares
`timescale 1ns / 1ps
module fpt_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic [4:0]         in_calib_index,
  input  logic signed [31:0] in_calib_word,
  input  logic signed [31:0] in_px,
  input  logic signed [31:0] in_py,
  input  logic signed [31:0] in_pz,
  input  logic signed [31:0] in_qw,
  input  logic [1:0]         in_from_frame,
  input  logic [1:0]         in_to_frame,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_x,
  input  logic signed [31:0] out_y,
  input  logic signed [31:0] out_z,
  output int                 fail_count,
  output int                 pending,
  output int                 point_count
);
  import fpt_pkg::*;

  typedef logic signed [31:0] word_t;
  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
  } point_t;

  word_t  calib[21];
  word_t  gw[9];
  point_t expected_points[$];

  // rounded q30 product
  function automatic longint qmul(word_t a, word_t b);
    longint p;
    p = longint'(a) * longint'(b) + (64'sd1 <<< 29);
    return p >>> 30;
  endfunction

  function automatic word_t clamp(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return word_t'(v);
  endfunction

  // m * v (+ add), or m transposed when tr
  function automatic void rotate(input word_t m[9], input bit tr, input word_t v[3],
                                 input longint add[3], output word_t r[3]);
    longint acc;
    for (int i = 0; i < 3; i++) begin
      acc = add[i];
      for (int k = 0; k < 3; k++)
        acc += qmul(tr ? m[k*3+i] : m[i*3+k], v[k]);
      r[i] = clamp(acc);
    end
  endfunction

  task automatic apply_imu(word_t x, word_t y, word_t z, word_t w);
    word_t rq[9], tmp[9], gi[9];
    longint xx, yy, zz, xy, xz, yz, xw, yw, zw, acc;
    xx = qmul(x, x); yy = qmul(y, y); zz = qmul(z, z);
    xy = qmul(x, y); xz = qmul(x, z); yz = qmul(y, z);
    xw = qmul(x, w); yw = qmul(y, w); zw = qmul(z, w);
    for (int i = 0; i < 9; i++) gi[i] = calib[9+i];
    rq[0] = clamp((64'sd1 <<< 30) - 2 * (yy + zz));
    rq[1] = clamp(2 * (xy - zw));
    rq[2] = clamp(2 * (xz + yw));
    rq[3] = clamp(2 * (xy + zw));
    rq[4] = clamp((64'sd1 <<< 30) - 2 * (xx + zz));
    rq[5] = clamp(2 * (yz - xw));
    rq[6] = clamp(2 * (xz - yw));
    rq[7] = clamp(2 * (yz + xw));
    rq[8] = clamp((64'sd1 <<< 30) - 2 * (xx + yy));
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += qmul(rq[i*3+k], gi[k*3+j]);
        tmp[i*3+j] = clamp(acc);
      end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += qmul(gi[k*3+i], tmp[k*3+j]);
        gw[i*3+j] = clamp(acc);
      end
  endtask

  function automatic point_t move_point(word_t p[3], logic [1:0] src, logic [1:0] dst);
    word_t rcg[9], wv[3], g[3], d[3], r[3];
    longint t[3], zero[3];
    for (int i = 0; i < 9; i++) rcg[i] = calib[i];
    for (int i = 0; i < 3; i++) begin
      t[i] = calib[18+i];
      zero[i] = 0;
    end
    if (src == dst) return '{p[0], p[1], p[2]};
    if (src == FR_CAM) begin
      rotate(rcg, 1'b0, p, t, g);
      rotate(gw, 1'b0, g, zero, wv);
    end else if (src == FR_GIM) begin
      rotate(gw, 1'b0, p, zero, wv);
    end else begin
      wv = p;
    end
    if (dst == FR_CAM) begin
      rotate(gw, 1'b1, wv, zero, g);
      for (int i = 0; i < 3; i++) d[i] = clamp(longint'(g[i]) - t[i]);
      rotate(rcg, 1'b1, d, zero, r);
    end else if (dst == FR_GIM) begin
      rotate(gw, 1'b1, wv, zero, r);
    end else begin
      r = wv;
    end
    return '{r[0], r[1], r[2]};
  endfunction

  assign pending = expected_points.size();

  // predict on input accept, compare on output accept
  always @(posedge clk) begin
    word_t  p[3];
    point_t e;
    if (!rst_n) begin
      for (int i = 0; i < 21; i++) calib[i] = 0;
      for (int i = 0; i < 9; i++) gw[i] = 0;
      for (int i = 0; i < 3; i++) begin
        calib[i*4] = ONE_Q30;
        calib[9+i*4] = ONE_Q30;
        gw[i*4] = ONE_Q30;
      end
      expected_points.delete();
      fail_count = 0;
      point_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        point_count++;
        if (expected_points.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h %h %h", out_x, out_y, out_z);
        end else begin
          e = expected_points.pop_front();
          if (e.x !== out_x || e.y !== out_y || e.z !== out_z) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %h %h %h, got %h %h %h",
                       e.x, e.y, e.z, out_x, out_y, out_z);
          end
        end
      end
      if (in_valid && !in_stall) begin
        p[0] = in_px; p[1] = in_py; p[2] = in_pz;
        case (cmd_t'(in_cmd))
          CMD_LOAD:  if (in_calib_index < CALIB_DEPTH) calib[in_calib_index] = in_calib_word;
          CMD_IMU:   apply_imu(in_px, in_py, in_pz, in_qw);
          CMD_XFORM: expected_points.push_back(move_point(p, in_from_frame, in_to_frame));
          default: ;
        endcase
      end
    end
  end

endmodule

>>> bench/tb_top.sv
// testbench top for the frame point transform: stimulus and verdict
`timescale 1ns / 1ps
module tb_top;
  import fpt_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_stall, out_valid, out_stall = 1'b0;
  logic [1:0] in_cmd = '0, in_from_frame = '0, in_to_frame = '0;
  logic [4:0] in_calib_index = '0;
  logic signed [31:0] in_calib_word = '0, in_px = '0, in_py = '0, in_pz = '0, in_qw = '0;
  logic signed [31:0] out_x, out_y, out_z;
  int fail_count, pending, point_count;
  int idle_cycles = 0;
  bit long_hold = 1'b0;
  bit done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  frame_point_transform_top DUT (.*);

  fpt_checker checker_i (.*);

  // watchdog on cycles without any accept
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("frame_point_transform_top test failed");
      $finish;
    end
  end

  // receiver: random stall per item, plus one long hold-off
  initial begin
    int w;
    @(posedge rst_n);
    while (!done) begin
      @(negedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (600) @(negedge clk);
        long_hold = 1'b0;
        out_stall <= 1'b0;
      end else if (out_valid && !out_stall) begin
        w = $urandom_range(0, 4);
        if (w > 0) begin
          out_stall <= 1'b1;
          repeat (w - 1) @(negedge clk);
          @(negedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3: return $signed($urandom_range(0, 65535) - 32768) <<< 14;
      default: return $urandom;
    endcase
  endfunction

  // one item, held until accepted, then a random gap when gaps is set
  task automatic send(logic [1:0] c, logic [4:0] idx, logic signed [31:0] wd,
                      logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z,
                      logic signed [31:0] qw, logic [1:0] f, logic [1:0] t, bit gaps);
    int g;
    in_valid <= 1'b1;
    in_cmd <= c; in_calib_index <= idx; in_calib_word <= wd;
    in_px <= x; in_py <= y; in_pz <= z; in_qw <= qw;
    in_from_frame <= f; in_to_frame <= t;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    g = gaps ? $urandom_range(0, 4) : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
      @(negedge clk);
    end
  endtask

  task automatic rand_item(bit gaps);
    int k;
    k = $urandom_range(0, 19);
    if (k < 4)
      send(CMD_LOAD, 5'($urandom_range(0, 31) % ((k == 0) ? 32 : 21)), rand_word(),
           rand_word(), rand_word(), rand_word(), rand_word(), 2'($urandom), 2'($urandom),
           gaps);
    else if (k < 6)
      send(CMD_IMU, 5'($urandom), rand_word(), rand_word(), rand_word(), rand_word(),
           rand_word(), 2'($urandom), 2'($urandom), gaps);
    else if (k == 6)
      send(CMD_NONE, 5'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
           2'($urandom), 2'($urandom), gaps);
    else
      send(CMD_XFORM, 5'($urandom), $urandom, rand_word(), rand_word(), rand_word(),
           rand_word(), 2'($urandom), 2'($urandom), gaps);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed: identity paths, every frame pair, extremes
    for (int f = 0; f < 4; f++)
      for (int t = 0; t < 4; t++)
        send(CMD_XFORM, 5'd0, 32'sd0, 32'sh7fffffff, 32'sh80000000, 32'sh00010000, 32'sd0,
             2'(f), 2'(t), 1'b0);
    send(CMD_LOAD, 5'd18, 32'sh7fffffff, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 2'd0, 2'd0, 1'b0);
    send(CMD_LOAD, 5'd1, 32'sh80000000, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 2'd0, 2'd0, 1'b0);
    send(CMD_LOAD, 5'd25, 32'sh12345678, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 2'd0, 2'd0, 1'b0);
    send(CMD_IMU, 5'd0, 32'sd0, 32'sh7fffffff, 32'sh80000000, 32'sh20000000, 32'sh7fffffff,
         2'd0, 2'd0, 1'b0);
    send(CMD_NONE, 5'd31, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 2'd3, 2'd3, 1'b0);
    send(CMD_XFORM, 5'd0, 32'sd0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sd0,
         2'd0, 2'd1, 1'b0);
    send(CMD_XFORM, 5'd0, 32'sd0, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sd0,
         2'd1, 2'd0, 1'b0);
    // random with gaps
    for (int i = 0; i < 300; i++) rand_item(1'b1);
    // long receiver hold-off while the sender keeps offering
    long_hold = 1'b1;
    for (int i = 0; i < 40; i++) rand_item(1'b0);
    // sender pauses until all results are in
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (100) @(negedge clk);
    for (int i = 0; i < 360; i++) rand_item(i % 50 < 40);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (200) @(posedge clk);
    done = 1'b1;
    $display("ran directed frame pairs, calibration loads, imu updates and %0d results",
             point_count);
    if (fail_count == 0) $display("frame_point_transform_top test passed");
    else $display("frame_point_transform_top test failed");
    $finish;
  end

endmodule
